// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/u8d_pkg.sv =====
// Shared types, constants and lead-byte decode for the UTF-8 decoder.
package u8d_pkg;

  localparam int ByteWidth         = 8;
  localparam int CpWidth           = 21;
  localparam int MaxResults        = 4;
  localparam int IdxWidth          = $clog2(MaxResults);
  localparam int QueueDepthDefault = 2;

  localparam logic [1:0] ContTag  = 2'h2;
  localparam logic [2:0] Lead2Tag = 3'h6;
  localparam logic [3:0] Lead3Tag = 4'hE;
  localparam logic [4:0] Lead4Tag = 5'h1E;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenOne  = 3'd1;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  typedef struct packed {
    logic [2:0]         len;
    logic [CpWidth-1:0] payload;
  } lead_info_t;

  // One queue entry: all results caused by one input byte.
  typedef struct packed {
    logic [MaxResults-1:0][CpWidth-1:0] vals;
    logic [IdxWidth-1:0]                last_idx;
    logic                               eot;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic lead_info_t lead_info(input logic [ByteWidth-1:0] b);
    lead_info_t r;
    r.len     = LenOne;
    r.payload = CpWidth'(b);
    if (!b[7]) begin
      r.len = LenOne;
    end else if (b[7:5] == Lead2Tag) begin
      r.len     = LenTwo;
      r.payload = CpWidth'(b[4:0]);
    end else if (b[7:4] == Lead3Tag) begin
      r.len     = LenThree;
      r.payload = CpWidth'(b[3:0]);
    end else if (b[7:3] == Lead4Tag) begin
      r.len     = LenFour;
      r.payload = CpWidth'(b[2:0]);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/u8d_byte_if.sv =====
// Byte input channel: valid/ready with data byte and end-of-text mark.
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

// ===== hw/rtl/u8d_cp_if.sv =====
// Code point output channel: valid/ready with code point and last marks.
interface u8d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        last_of_input;
  logic        last_of_text;

  modport source (output valid, output code_point, output last_of_input,
                  output last_of_text, input ready);
  modport sink   (input valid, input code_point, input last_of_input,
                  input last_of_text, output ready);
endinterface

// ===== hw/rtl/u8d_front.sv =====
// Front end: accepts bytes, tracks the open sequence, builds result groups.
module u8d_front (
  input  logic                clk,
  input  logic                rst,
  u8d_byte_if.sink            text,
  input  u8d_pkg::q_status_t  status,
  output u8d_pkg::push_t      push
);
  import u8d_pkg::*;

  logic [ByteWidth-1:0] pending_lead, pending_lead_next;
  logic [2:0]           exp_len, exp_len_next;
  logic [1:0]           cseen, cseen_next;
  logic [CpWidth-1:0]   acc, acc_next;
  logic [ByteWidth-1:0] held [2];

  logic [ByteWidth-1:0] b;
  logic                 eot, accept, cont, seq_open, complete, fresh_emit;
  logic                 emit, final_on, hold_wr;
  logic [IdxWidth-1:0]  first_idx, flush_n;
  logic [CpWidth-1:0]   final_val, acc_cont;
  lead_info_t           li;

  assign text.ready = !status.full;

  always_comb begin
    b          = text.data_byte;
    eot        = text.end_of_text;
    accept     = text.valid && !status.full;
    cont       = b[7:6] == ContTag;
    seq_open   = exp_len != LenNone;
    li         = lead_info(b);
    acc_cont   = {acc[CpWidth-7:0], b[5:0]};
    complete   = ({1'b0, cseen} + LenTwo) >= exp_len;
    flush_n    = (cseen >= 2'd2) ? IdxWidth'(3) : IdxWidth'(cseen + 2'd1);
    fresh_emit = (li.len == LenOne) || eot;

    emit      = 1'b0;
    final_on  = 1'b0;
    hold_wr   = 1'b0;
    first_idx = '0;
    final_val = CpWidth'(b);

    pending_lead_next = pending_lead;
    exp_len_next      = exp_len;
    cseen_next        = cseen;
    acc_next          = acc;

    if (seq_open && cont) begin
      if (complete) begin
        emit      = 1'b1;
        final_on  = 1'b1;
        final_val = acc_cont;
      end else if (eot) begin
        emit      = 1'b1;
        final_on  = 1'b1;
        first_idx = flush_n;
      end else begin
        hold_wr    = 1'b1;
        cseen_next = cseen + 2'd1;
        acc_next   = acc_cont;
      end
      if (complete || eot) begin
        pending_lead_next = '0;
        exp_len_next      = LenNone;
        cseen_next        = '0;
        acc_next          = '0;
      end
    end else begin
      if (seq_open) begin
        emit      = 1'b1;
        first_idx = flush_n;
      end
      if (fresh_emit) begin
        emit              = 1'b1;
        final_on          = 1'b1;
        pending_lead_next = '0;
        exp_len_next      = LenNone;
        cseen_next        = '0;
        acc_next          = '0;
      end else begin
        pending_lead_next = b;
        exp_len_next      = li.len;
        cseen_next        = '0;
        acc_next          = li.payload;
      end
    end
  end

  always_comb begin
    push.push           = accept && emit;
    push.entry.eot      = eot;
    push.entry.vals[0]  = CpWidth'(pending_lead);
    push.entry.vals[1]  = CpWidth'(held[0]);
    push.entry.vals[2]  = CpWidth'(held[1]);
    push.entry.vals[3]  = '0;
    push.entry.vals[first_idx] = final_val;
    push.entry.last_idx = final_on ? first_idx : first_idx - IdxWidth'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_lead <= '0;
      exp_len      <= LenNone;
      cseen        <= '0;
      acc          <= '0;
    end else if (accept) begin
      pending_lead <= pending_lead_next;
      exp_len      <= exp_len_next;
      cseen        <= cseen_next;
      acc          <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_wr) begin
      held[cseen[0]] <= b;
    end
  end

endmodule

// ===== hw/rtl/u8d_queue.sv =====
// Short queue of result groups between the front and back ends.
module u8d_queue #(
  parameter int Depth = u8d_pkg::QueueDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  u8d_pkg::push_t     push,
  input  logic               pop,
  output u8d_pkg::entry_t    head,
  output u8d_pkg::q_status_t status
);
  import u8d_pkg::*;

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);

  entry_t                slots [Depth];
  logic [PtrWidth-1:0]   wr_ptr, rd_ptr;
  logic [CntWidth-1:0]   count;
  logic                  do_push, do_pop;

  assign status.full  = count == CntWidth'(Depth);
  assign status.empty = count == '0;
  assign do_push      = push.push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(Depth - 1)) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(Depth - 1)) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntWidth'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

endmodule

// ===== hw/rtl/u8d_back.sv =====
// Back end: holds one result group and sends its code points one per transfer.
module u8d_back (
  input  logic               clk,
  input  logic               rst,
  input  u8d_pkg::entry_t    head,
  input  u8d_pkg::q_status_t status,
  output logic               pop,
  u8d_cp_if.source           points
);
  import u8d_pkg::*;

  entry_t              cur;
  logic                cur_valid;
  logic [IdxWidth-1:0] idx;
  logic                fire, at_last, need_load;

  always_comb begin
    fire      = cur_valid && points.ready;
    at_last   = idx == cur.last_idx;
    need_load = !cur_valid || (fire && at_last);
    pop       = need_load && !status.empty;

    points.valid         = cur_valid;
    points.code_point    = cur.vals[idx];
    points.last_of_input = at_last;
    points.last_of_text  = at_last && cur.eot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (need_load) begin
      cur_valid <= !status.empty;
      idx       <= '0;
    end else if (fire) begin
      idx <= idx + IdxWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

// ===== hw/rtl/utf8_byte_to_codepoint_decoder.sv =====
// Top level of the UTF-8 byte to code point decoder.
// Takes one byte per cycle while the queue is not full and gives code points,
// one per output transfer. The front end decodes a byte in its accept cycle
// and queues the group of results it causes (none to four); the back end sends
// them one per cycle while the output is ready, so a byte that yields one
// result sustains one byte per cycle. A broken or cut-off sequence flushes up
// to four raw values, and while the back end drains such a group the input
// stalls once the QueueDepth-entry queue fills. Results pass through the queue
// slot and the back-end group register before they reach the output.
module utf8_byte_to_codepoint_decoder #(
  parameter int QueueDepth = u8d_pkg::QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst,
  u8d_byte_if.sink  text,
  u8d_cp_if.source  points
);
  import u8d_pkg::*;

  push_t     push;
  entry_t    head;
  q_status_t status;
  logic      pop;

  u8d_front front (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .status (status),
    .push   (push)
  );

  u8d_queue #(.Depth(QueueDepth)) queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (status)
  );

  u8d_back back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .status (status),
    .pop    (pop),
    .points (points)
  );

endmodule

// ===== hw/rtl/u8d_checker.sv =====
// Port-level checks for the UTF-8 decoder, bound to the top level.
`include "assert_macros.svh"

module u8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic        last_of_input,
  input logic        last_of_text
);

  `ASSERT_CLK_ALWAYS(a_idle_after_reset, clk, rst |=> !out_valid, "output valid after reset")

  `ASSERT_CLK(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(last_of_input) && $stable(last_of_text), "stalled result changed")

  `ASSERT_CLK(a_text_end_closes_group, clk, rst, out_valid && last_of_text |-> last_of_input, "end of text not on last result of a byte")

endmodule

bind utf8_byte_to_codepoint_decoder u8d_checker checker_inst (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (points.valid),
  .out_ready     (points.ready),
  .code_point    (points.code_point),
  .last_of_input (points.last_of_input),
  .last_of_text  (points.last_of_text)
);

// ===== tb/sv/tb_utf8_byte_to_codepoint_decoder.sv =====
// Self-checking testbench for the UTF-8 byte to code point decoder.
module tb_utf8_byte_to_codepoint_decoder;
  import u8d_pkg::*;

  localparam int RandomItems = 400;
  localparam int StallLimit  = 2000;
  localparam int ReportLimit = 10;
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic [7:0]         b;
    logic               eot;
    logic               typed;
    logic [2:0]         n;
    logic [0:3][20:0]   cps;
  } byte_row_t;

  typedef struct packed {
    logic [20:0] cp;
    logic        last_in;
    logic        last_txt;
  } point_t;

  // typed=1: expected points typed in here; typed=0: taken from decode_byte
  localparam int DirectedCount = 25;
  localparam byte_row_t DirectedRows [DirectedCount] = '{
    '{8'h00, 1'b0, 1'b1, 3'd1, '{21'h000000, 0, 0, 0}},
    '{8'h7F, 1'b0, 1'b1, 3'd1, '{21'h00007F, 0, 0, 0}},
    '{8'h80, 1'b0, 1'b1, 3'd1, '{21'h000080, 0, 0, 0}},
    '{8'hFF, 1'b0, 1'b1, 3'd1, '{21'h0000FF, 0, 0, 0}},
    '{8'hF8, 1'b0, 1'b1, 3'd1, '{21'h0000F8, 0, 0, 0}},
    '{8'hC2, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{8'hA9, 1'b0, 1'b0, 3'd0, '{0, 0, 0, 0}},
    '{8'hE2, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{8'h82, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{8'hAC, 1'b0, 1'b0, 3'd0, '{0, 0, 0, 0}},
    '{8'hF7, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{8'hBF, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{8'hBF, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{8'hBF, 1'b0, 1'b1, 3'd1, '{21'h1FFFFF, 0, 0, 0}},
    '{8'hF0, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{8'h9F, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{8'h98, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{8'h41, 1'b0, 1'b1, 3'd4, '{21'h0000F0, 21'h00009F, 21'h000098, 21'h000041}},
    '{8'hE0, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{8'h80, 1'b1, 1'b1, 3'd2, '{21'h0000E0, 21'h000080, 0, 0}},
    '{8'hDF, 1'b1, 1'b1, 3'd1, '{21'h0000DF, 0, 0, 0}},
    '{8'hC0, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{8'hC3, 1'b0, 1'b1, 3'd1, '{21'h0000C0, 0, 0, 0}},
    '{8'h80, 1'b1, 1'b0, 3'd0, '{0, 0, 0, 0}},
    '{8'h7F, 1'b1, 1'b1, 3'd1, '{21'h00007F, 0, 0, 0}}
  };

  logic clk;
  logic rst;
  logic steady;

  u8d_byte_if text_if();
  u8d_cp_if   points_if();

  utf8_byte_to_codepoint_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if),
    .points (points_if)
  );

  // decoder state mirror
  logic [7:0]  dec_lead = '0;
  logic [2:0]  dec_len  = LenNone;
  logic [1:0]  dec_seen = '0;
  logic [20:0] dec_acc  = '0;
  logic [7:0]  dec_held [2] = '{8'h00, 8'h00};
  logic [20:0] step_vals [4];
  int          step_cnt;

  byte_row_t   bytes_in_flight [$];
  point_t      expected_points [$];
  int          fail_count  = 0;
  int          idle_cycles = 0;
  logic [7:0]  text_bytes [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task emit(input logic [20:0] v);
    step_vals[step_cnt] = v;
    step_cnt++;
  endtask

  task close_seq();
    dec_len  = LenNone;
    dec_seen = '0;
    dec_acc  = '0;
    dec_lead = '0;
  endtask

  task flush_seq();
    emit(21'(dec_lead));
    for (int k = 0; k < dec_seen && k < 2; k++) emit(21'(dec_held[k]));
    close_seq();
  endtask

  task start_fresh(input logic [7:0] b, input logic eot);
    logic [2:0]  len;
    logic [20:0] pay;
    len = LenOne;
    pay = 21'(b);
    if (b[7]) begin
      if (b[7:5] == Lead2Tag) begin
        len = LenTwo;
        pay = 21'(b[4:0]);
      end else if (b[7:4] == Lead3Tag) begin
        len = LenThree;
        pay = 21'(b[3:0]);
      end else if (b[7:3] == Lead4Tag) begin
        len = LenFour;
        pay = 21'(b[2:0]);
      end
    end
    if (len == LenOne || eot) begin
      emit(21'(b));
    end else begin
      dec_lead = b;
      dec_len  = len;
      dec_seen = '0;
      dec_acc  = pay;
    end
  endtask

  task decode_byte(input logic [7:0] b, input logic eot);
    step_cnt = 0;
    if (dec_len != LenNone) begin
      if (b[7:6] == ContTag) begin
        dec_acc = {dec_acc[14:0], b[5:0]};
        if ({1'b0, dec_seen} + 3'd2 >= dec_len) begin
          emit(dec_acc);
          close_seq();
        end else if (eot) begin
          flush_seq();
          emit(21'(b));
        end else begin
          dec_held[dec_seen[0]] = b;
          dec_seen = dec_seen + 2'd1;
        end
      end else begin
        flush_seq();
        start_fresh(b, eot);
      end
    end else begin
      start_fresh(b, eot);
    end
  endtask

  always @(posedge clk) begin : monitor
    byte_row_t row;
    point_t    want;
    point_t    got;
    int        cnt;
    if (!rst) begin
      if ((text_if.valid && text_if.ready) || (points_if.valid && points_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (text_if.valid && text_if.ready) begin
        row = bytes_in_flight.pop_front();
        decode_byte(text_if.data_byte, text_if.end_of_text);
        cnt = row.typed ? int'(row.n) : step_cnt;
        for (int i = 0; i < cnt; i++) begin
          want.cp       = row.typed ? row.cps[i] : step_vals[i];
          want.last_in  = (i == cnt - 1);
          want.last_txt = (i == cnt - 1) && text_if.end_of_text;
          expected_points.insert(expected_points.size(), want);
        end
      end
      if (points_if.valid && points_if.ready) begin
        got = '{points_if.code_point, points_if.last_of_input, points_if.last_of_text};
        if (expected_points.size() == 0) begin
          if (fail_count < ReportLimit)
            $display("unexpected code point %h (last_of_input=%b last_of_text=%b)",
                     got.cp, got.last_in, got.last_txt);
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          if (got.cp !== want.cp || got.last_in !== want.last_in ||
              got.last_txt !== want.last_txt) begin
            if (fail_count < ReportLimit)
              $display("mismatch: expected cp=%h loi=%b lot=%b, got cp=%h loi=%b lot=%b",
                       want.cp, want.last_in, want.last_txt,
                       got.cp, got.last_in, got.last_txt);
            fail_count++;
          end
        end
      end
    end
  end

  // output side back-pressure
  always @(posedge clk) begin : point_sink
    int hold;
    if (rst) begin
      points_if.ready <= 1'b0;
      hold = 0;
    end else if (steady) begin
      points_if.ready <= 1'b1;
    end else if (hold != 0) begin
      hold--;
    end else if (points_if.ready) begin
      points_if.ready <= 1'b0;
      hold = pick_gap();
    end else begin
      points_if.ready <= 1'b1;
      hold = $urandom_range(0, 12);
    end
  end

  task send_byte(input byte_row_t row);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bytes_in_flight.insert(bytes_in_flight.size(), row);
    text_if.valid       <= 1'b1;
    text_if.data_byte   <= row.b;
    text_if.end_of_text <= row.eot;
    do @(posedge clk); while (!text_if.ready);
  endtask

  task add_seq(input int len, input int keep);
    case (len)
      2:       text_bytes.insert(text_bytes.size(), {3'b110, 5'($urandom_range(0, 31))});
      3:       text_bytes.insert(text_bytes.size(), {4'b1110, 4'($urandom_range(0, 15))});
      default: text_bytes.insert(text_bytes.size(), {5'b11110, 3'($urandom_range(0, 7))});
    endcase
    for (int i = 1; i < keep; i++)
      text_bytes.insert(text_bytes.size(), {2'b10, 6'($urandom_range(0, 63))});
  endtask

  initial begin : watchdog
    do @(posedge clk); while (idle_cycles < StallLimit);
    $display("tb_utf8_byte_to_codepoint_decoder failed");
    $finish;
  end

  initial begin : stimulus
    byte_row_t row;
    int        sent;
    int        kind;
    int        len;
    rst                 <= 1'b1;
    steady              <= 1'b0;
    text_if.valid       <= 1'b0;
    text_if.data_byte   <= '0;
    text_if.end_of_text <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DirectedCount; i++) send_byte(DirectedRows[i]);

    sent = 0;
    while (sent < RandomItems) begin
      text_bytes.delete();
      steady <= ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(1, 12)) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 127)));
        end else if (kind < 50) begin
          add_seq(2, 2);
        end else if (kind < 68) begin
          add_seq(3, 3);
        end else if (kind < 85) begin
          add_seq(4, 4);
        end else if (kind < 93) begin
          len = $urandom_range(2, 4);
          add_seq(len, $urandom_range(1, len - 1));
        end else begin
          text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 255)));
        end
      end
      foreach (text_bytes[i]) begin
        row       = '0;
        row.b     = text_bytes[i];
        row.eot   = (i == text_bytes.size() - 1) || ($urandom_range(0, 59) == 0);
        row.typed = 1'b0;
        send_byte(row);
        sent++;
      end
    end
    text_if.valid <= 1'b0;
    steady        <= 1'b0;

    while (expected_points.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("tb_utf8_byte_to_codepoint_decoder passed");
    end else begin
      $display("tb_utf8_byte_to_codepoint_decoder failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_byte_if.sv
hw/rtl/u8d_cp_if.sv
hw/rtl/u8d_front.sv
hw/rtl/u8d_queue.sv
hw/rtl/u8d_back.sv
hw/rtl/utf8_byte_to_codepoint_decoder.sv
hw/rtl/u8d_checker.sv
tb/sv/tb_utf8_byte_to_codepoint_decoder.sv
